[src/vafc_pkg.sv]
`timescale 1ns / 1ps

package vafc_pkg;

   typedef struct packed {
      logic        mode;
      logic [31:0] index;
      logic [63:0] raw_0;
      logic [63:0] raw_1;
      logic [63:0] raw_2;
      logic [63:0] raw_3;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [43:0] byte_offset;
      logic [63:0] comp_0;
      logic [63:0] comp_1;
      logic [63:0] comp_2;
      logic [63:0] comp_3;
   } rsp_type;

   typedef struct packed {
      logic [3:0] attr_type;
      logic       normalized;
   } lane_cfg_type;

   localparam logic [3:0] ATTR_S8       = 4'd0;
   localparam logic [3:0] ATTR_U8       = 4'd1;
   localparam logic [3:0] ATTR_S16      = 4'd2;
   localparam logic [3:0] ATTR_U16      = 4'd3;
   localparam logic [3:0] ATTR_S32      = 4'd4;
   localparam logic [3:0] ATTR_U32      = 4'd5;
   localparam logic [3:0] ATTR_HALF     = 4'd6;
   localparam logic [3:0] ATTR_FLOAT    = 4'd7;
   localparam logic [3:0] ATTR_DOUBLE   = 4'd8;
   localparam logic [3:0] ATTR_FIXED    = 4'd9;
   localparam logic [3:0] ATTR_S2101010 = 4'd10;
   localparam logic [3:0] ATTR_U2101010 = 4'd11;
   localparam logic [3:0] ATTR_F101111  = 4'd12;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_SIZE = 2'd1;
   localparam logic [1:0] STAT_TYPE = 2'd2;
   localparam logic [1:0] STAT_OOB  = 2'd3;

   localparam logic [2:0] CSR_ATTR_TYPE     = 3'd0;
   localparam logic [2:0] CSR_COMP_COUNT    = 3'd1;
   localparam logic [2:0] CSR_NORMALIZED    = 3'd2;
   localparam logic [2:0] CSR_STRIDE        = 3'd3;
   localparam logic [2:0] CSR_BASE_OFFSET   = 3'd4;
   localparam logic [2:0] CSR_BUFFER_LENGTH = 3'd5;

endpackage

[src/vafc_lane.sv]
`timescale 1ns / 1ps

module vafc_lane #(
   parameter int LANE = 0
) (
   input  logic                   clock,
   input  logic [6:2]             stage_en,
   input  vafc_pkg::lane_cfg_type cfg,
   input  logic                   mode_in,
   input  logic [255:0]           raw_in,
   output logic [63:0]            comp_out
);

   typedef enum logic [3:0] {
      PER_2, PER_7, PER_8, PER_9, PER_10, PER_15, PER_16, PER_31, PER_32
   } period_type;

   function automatic logic [63:0] half_to_double(input logic [15:0] h);
      logic [9:0]  m;
      logic [4:0]  e;
      logic [3:0]  k;
      logic [9:0]  ms;
      logic [63:0] d;
      m = h[9:0];
      e = h[14:10];
      k = '0;
      for (int i = 0; i < 10; i++) begin
         if (m[i]) k = 4'(10 - i);
      end
      ms = m << k;
      d = {h[15], 63'b0};
      if (e == 5'd0) begin
         if (m != 10'd0) d = {h[15], 11'(11'd1009 - 11'(k)), ms, 42'b0};
      end else if (e == 5'h1F) begin
         d = {h[15], 11'h7FF, m[9] | (m != 10'd0), m[8:0], 42'b0};
      end else begin
         d = {h[15], 11'(11'd1008 + 11'(e)), m, 42'b0};
      end
      return d;
   endfunction

   function automatic logic [63:0] single_to_double(input logic [31:0] f);
      logic [22:0] m;
      logic [7:0]  e;
      logic [4:0]  k;
      logic [22:0] ms;
      logic [63:0] d;
      m = f[22:0];
      e = f[30:23];
      k = '0;
      for (int i = 0; i < 23; i++) begin
         if (m[i]) k = 5'(23 - i);
      end
      ms = m << k;
      d = {f[31], 63'b0};
      if (e == 8'd0) begin
         if (m != 23'd0) d = {f[31], 11'(11'd897 - 11'(k)), ms, 29'b0};
      end else if (e == 8'hFF) begin
         d = {f[31], 11'h7FF, m[22] | (m != 23'd0), m[21:0], 29'b0};
      end else begin
         d = {f[31], 11'(11'd896 + 11'(e)), m, 29'b0};
      end
      return d;
   endfunction

   function automatic logic [32:0] max_of(input period_type p);
      logic [32:0] v;
      case (p)
         PER_2:   v = 33'h3;
         PER_7:   v = 33'h7F;
         PER_8:   v = 33'hFF;
         PER_9:   v = 33'h1FF;
         PER_10:  v = 33'h3FF;
         PER_15:  v = 33'h7FFF;
         PER_16:  v = 33'hFFFF;
         PER_31:  v = 33'h7FFFFFFF;
         PER_32:  v = 33'hFFFFFFFF;
         default: v = 33'hFF;
      endcase
      return v;
   endfunction

   // repeating binary fraction r / (2^n - 1), top-aligned
   function automatic logic [95:0] tile(input logic [31:0] r, input period_type p);
      logic [127:0] w;
      logic [95:0]  t;
      w = '0;
      t = '0;
      case (p)
         PER_2:   begin w = 128'({48{r[1:0]}});  t = w[95:0];  end
         PER_7:   begin w = 128'({14{r[6:0]}});  t = w[97:2];  end
         PER_8:   begin w = 128'({12{r[7:0]}});  t = w[95:0];  end
         PER_9:   begin w = 128'({11{r[8:0]}});  t = w[98:3];  end
         PER_10:  begin w = 128'({10{r[9:0]}});  t = w[99:4];  end
         PER_15:  begin w = 128'({7{r[14:0]}});  t = w[104:9]; end
         PER_16:  begin w = 128'({6{r[15:0]}});  t = w[95:0];  end
         PER_31:  begin w = 128'({4{r[30:0]}});  t = w[123:28]; end
         PER_32:  begin w = 128'({3{r[31:0]}});  t = w[95:0];  end
         default: begin w = '0; t = '0; end
      endcase
      return t;
   endfunction

   function automatic logic [4:0] lzc32(input logic [31:0] x);
      logic [4:0] n;
      n = '0;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) n = 5'(31 - i);
      end
      return n;
   endfunction

   // stage 2: field decode
   logic signed [32:0] sval_in;
   logic [32:0]        smag_in;
   logic               flt_in;
   logic               pack_in;
   logic               normq_in;
   period_type         per_in;
   logic [63:0]        dd_in;

   always_comb begin
      sval_in  = '0;
      flt_in   = 1'b0;
      pack_in  = 1'b0;
      normq_in = 1'b0;
      per_in   = PER_8;
      dd_in    = raw_in[64*LANE +: 64];
      case (cfg.attr_type)
         vafc_pkg::ATTR_S8: begin
            sval_in  = {{25{raw_in[8*LANE+7]}}, raw_in[8*LANE +: 8]};
            per_in   = PER_7;
            normq_in = cfg.normalized;
         end
         vafc_pkg::ATTR_U8: begin
            sval_in  = {25'b0, raw_in[8*LANE +: 8]};
            per_in   = PER_8;
            normq_in = cfg.normalized;
         end
         vafc_pkg::ATTR_S16: begin
            sval_in  = {{17{raw_in[16*LANE+15]}}, raw_in[16*LANE +: 16]};
            per_in   = PER_15;
            normq_in = cfg.normalized;
         end
         vafc_pkg::ATTR_U16: begin
            sval_in  = {17'b0, raw_in[16*LANE +: 16]};
            per_in   = PER_16;
            normq_in = cfg.normalized;
         end
         vafc_pkg::ATTR_S32: begin
            sval_in  = {raw_in[32*LANE+31], raw_in[32*LANE +: 32]};
            per_in   = PER_31;
            normq_in = cfg.normalized;
         end
         vafc_pkg::ATTR_U32: begin
            sval_in  = {1'b0, raw_in[32*LANE +: 32]};
            per_in   = PER_32;
            normq_in = cfg.normalized;
         end
         vafc_pkg::ATTR_HALF: begin
            flt_in = 1'b1;
            dd_in  = half_to_double(raw_in[16*LANE +: 16]);
         end
         vafc_pkg::ATTR_FLOAT: begin
            flt_in = 1'b1;
            dd_in  = single_to_double(raw_in[32*LANE +: 32]);
         end
         vafc_pkg::ATTR_DOUBLE: begin
            flt_in = 1'b1;
         end
         vafc_pkg::ATTR_S2101010: begin
            pack_in = 1'b1;
            if (LANE == 3) begin
               sval_in = {{31{raw_in[31]}}, raw_in[31:30]};
            end else begin
               sval_in  = {{23{raw_in[10*LANE+9]}}, raw_in[10*LANE +: 10]};
               per_in   = PER_9;
               normq_in = cfg.normalized;
            end
         end
         vafc_pkg::ATTR_U2101010: begin
            pack_in  = 1'b1;
            normq_in = cfg.normalized;
            if (LANE == 3) begin
               sval_in = {31'b0, raw_in[31:30]};
               per_in  = PER_2;
            end else begin
               sval_in = {23'b0, raw_in[10*LANE +: 10]};
               per_in  = PER_10;
            end
         end
         default: begin
            sval_in = '0;
         end
      endcase
      smag_in = sval_in[32] ? 33'(-sval_in) : 33'(sval_in);
   end

   logic        mode2_ff, neg2_ff, flt2_ff, pack2_ff, normq2_ff;
   logic [31:0] mag2_ff, ival2_ff;
   logic [63:0] dd2_ff;
   period_type  per2_ff;

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         mode2_ff  <= mode_in;
         neg2_ff   <= sval_in[32];
         mag2_ff   <= smag_in[31:0];
         ival2_ff  <= sval_in[31:0];
         dd2_ff    <= dd_in;
         flt2_ff   <= flt_in;
         pack2_ff  <= pack_in;
         normq2_ff <= normq_in && !flt_in;
         per2_ff   <= per_in;
      end
   end

   // stage 3: integer quotient by 2^n - 1, float-to-int prep
   logic [32:0] maxv_in;
   logic        q_in;
   logic [31:0] r_in;
   logic [10:0] fexp_in;

   always_comb begin
      maxv_in = max_of(per2_ff);
      q_in    = normq2_ff && ({1'b0, mag2_ff} >= maxv_in);
      r_in    = q_in ? 32'(mag2_ff - maxv_in[31:0]) : mag2_ff;
      fexp_in = dd2_ff[62:52];
   end

   logic        mode3_ff, neg3_ff, flt3_ff, pack3_ff, normq3_ff, q3_ff;
   logic [31:0] mag3_ff, ival3_ff, r3_ff;
   logic [63:0] dd3_ff;
   period_type  per3_ff;
   logic        fsgn3_ff, nan3_ff, big3_ff, small3_ff;
   logic [52:0] fman3_ff;
   logic [5:0]  fsh3_ff;

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         mode3_ff  <= mode2_ff;
         neg3_ff   <= neg2_ff;
         flt3_ff   <= flt2_ff;
         pack3_ff  <= pack2_ff;
         normq3_ff <= normq2_ff;
         q3_ff     <= q_in;
         mag3_ff   <= mag2_ff;
         ival3_ff  <= ival2_ff;
         r3_ff     <= r_in;
         dd3_ff    <= dd2_ff;
         per3_ff   <= per2_ff;
         fsgn3_ff  <= dd2_ff[63];
         nan3_ff   <= (fexp_in == 11'h7FF) && (dd2_ff[51:0] != 52'd0);
         big3_ff   <= fexp_in >= 11'd1054;
         small3_ff <= fexp_in < 11'd1023;
         fman3_ff  <= {1'b1, dd2_ff[51:0]};
         fsh3_ff   <= 6'(11'd1075 - fexp_in);
      end
   end

   // stage 4: leading-one search
   logic [95:0] src_in;
   logic [4:0]  lz_in;
   logic [10:0] exp_in;
   logic [5:0]  sh_in;
   logic        zero_in;
   logic [52:0] fsh_val;

   always_comb begin
      src_in  = normq3_ff ? tile(r3_ff, per3_ff) : {mag3_ff, 64'b0};
      lz_in   = lzc32(src_in[95:64]);
      zero_in = !q3_ff && (src_in[95:64] == 32'd0);
      if (q3_ff) begin
         exp_in = 11'd1023;
         sh_in  = 6'd0;
      end else begin
         exp_in = normq3_ff ? 11'(11'd1022 - 11'(lz_in)) : 11'(11'd1054 - 11'(lz_in));
         sh_in  = 6'(lz_in) + 6'd1;
      end
      fsh_val = fman3_ff >> fsh3_ff;
   end

   logic        mode4_ff, neg4_ff, flt4_ff, pack4_ff, zero4_ff;
   logic [31:0] ival4_ff;
   logic [63:0] dd4_ff;
   logic [95:0] src4_ff;
   logic [5:0]  sh4_ff;
   logic [10:0] exp4_ff;
   logic        fsgn4_ff, nan4_ff, big4_ff, small4_ff;
   logic [30:0] fmag4_ff;

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         mode4_ff  <= mode3_ff;
         neg4_ff   <= neg3_ff;
         flt4_ff   <= flt3_ff;
         pack4_ff  <= pack3_ff;
         zero4_ff  <= zero_in;
         ival4_ff  <= ival3_ff;
         dd4_ff    <= dd3_ff;
         src4_ff   <= src_in;
         sh4_ff    <= sh_in;
         exp4_ff   <= exp_in;
         fsgn4_ff  <= fsgn3_ff;
         nan4_ff   <= nan3_ff;
         big4_ff   <= big3_ff;
         small4_ff <= small3_ff;
         fmag4_ff  <= fsh_val[30:0];
      end
   end

   // stage 5: normalize shift, float-to-int sign
   logic [95:0] xs_in;
   logic [31:0] fint_in;

   always_comb begin
      xs_in = src4_ff << sh4_ff;
      if (nan4_ff) begin
         fint_in = '0;
      end else if (big4_ff) begin
         fint_in = fsgn4_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (small4_ff) begin
         fint_in = '0;
      end else begin
         fint_in = fsgn4_ff ? 32'(-{1'b0, fmag4_ff}) : {1'b0, fmag4_ff};
      end
   end

   logic        mode5_ff, neg5_ff, flt5_ff, pack5_ff, zero5_ff, guard5_ff;
   logic [31:0] ival5_ff, fint5_ff;
   logic [63:0] dd5_ff;
   logic [51:0] mant5_ff;
   logic [10:0] exp5_ff;

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         mode5_ff  <= mode4_ff;
         neg5_ff   <= neg4_ff;
         flt5_ff   <= flt4_ff;
         pack5_ff  <= pack4_ff;
         zero5_ff  <= zero4_ff;
         ival5_ff  <= ival4_ff;
         dd5_ff    <= dd4_ff;
         mant5_ff  <= xs_in[95:44];
         guard5_ff <= xs_in[43];
         exp5_ff   <= exp4_ff;
         fint5_ff  <= fint_in;
      end
   end

   // stage 6: round to double; inexact quotients never tie
   logic [52:0] rnd_in;
   logic [10:0] rexp_in;
   logic [63:0] dbl_in;

   always_comb begin
      rnd_in  = {1'b0, mant5_ff} + 53'(guard5_ff);
      rexp_in = exp5_ff + 11'(rnd_in[52]);
      dbl_in  = zero5_ff ? 64'd0 : {neg5_ff, rexp_in, rnd_in[51:0]};
   end

   logic        mode6_ff, flt6_ff, pack6_ff;
   logic [31:0] ival6_ff, fint6_ff;
   logic [63:0] dd6_ff, dbl6_ff;

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         mode6_ff <= mode5_ff;
         flt6_ff  <= flt5_ff;
         pack6_ff <= pack5_ff;
         ival6_ff <= ival5_ff;
         fint6_ff <= fint5_ff;
         dd6_ff   <= dd5_ff;
         dbl6_ff  <= dbl_in;
      end
   end

   // packed formats go through single precision
   logic        fup;
   logic [23:0] fm;
   logic [10:0] fe;
   logic [63:0] fr;

   always_comb begin
      fup = dbl6_ff[28] & (dbl6_ff[29] | (dbl6_ff[27:0] != 28'd0));
      fm  = {1'b0, dbl6_ff[51:29]} + 24'(fup);
      fe  = dbl6_ff[62:52] + 11'(fm[23]);
      fr  = {dbl6_ff[63], fe, fm[22:0], 29'b0};
      if (mode6_ff) begin
         comp_out = flt6_ff ? {{32{fint6_ff[31]}}, fint6_ff} : {{32{ival6_ff[31]}}, ival6_ff};
      end else if (flt6_ff) begin
         comp_out = dd6_ff;
      end else if (pack6_ff) begin
         comp_out = fr;
      end else begin
         comp_out = dbl6_ff;
      end
   end

endmodule

[src/vertex_attribute_fetch_convert.sv]
`timescale 1ns / 1ps

// Vertex attribute fetch and format conversion.
// req_*: one transaction per element: mode (0 double, 1 int32), element
//   index and the 32 raw bytes at the element start.
// rsp_*: status, byte offset and up to four components; fields beyond the
//   component count, and everything but status on an error, are zero.
// csr_*: register writes (attr_type, comp_count, normalized, stride,
//   base_offset, buffer_length by index 0..5); csr_ready is always high.
//   Write registers only while no transaction is in flight.
// From acceptance to rsp_valid the pipeline has one register stage for
//   the stride multiply, one for the offset add and bounds compare, then
//   the per-component converter stages (quotient, leading-one search,
//   normalize shift, rounding) and the output register.
// Throughput is one transaction per cycle. Each stage holds its own valid
//   bit, so a stall on rsp_ready backs up stage by stage and req_ready only
//   drops once all seven stages are full.
// Synchronous reset empties the pipeline and loads register defaults:
//   attr_type 0, comp_count 4, normalized 0, all others 0.
module vertex_attribute_fetch_convert #(
   parameter int MAX_COMPONENTS = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vafc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vafc_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data
);

   function automatic logic [3:0] type_bytes(input logic [3:0] t);
      logic [3:0] n;
      case (t)
         vafc_pkg::ATTR_S8, vafc_pkg::ATTR_U8: n = 4'd1;
         vafc_pkg::ATTR_S16, vafc_pkg::ATTR_U16, vafc_pkg::ATTR_HALF: n = 4'd2;
         vafc_pkg::ATTR_DOUBLE: n = 4'd8;
         vafc_pkg::ATTR_S32, vafc_pkg::ATTR_U32, vafc_pkg::ATTR_FLOAT,
         vafc_pkg::ATTR_FIXED, vafc_pkg::ATTR_S2101010, vafc_pkg::ATTR_U2101010,
         vafc_pkg::ATTR_F101111: n = 4'd4;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   logic [3:0]  type_ff;
   logic [2:0]  cnt_ff;
   logic        norm_ff;
   logic [11:0] stride_ff;
   logic [31:0] base_ff;
   logic [31:0] blen_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff   <= vafc_pkg::ATTR_S8;
         cnt_ff    <= 3'd4;
         norm_ff   <= 1'b0;
         stride_ff <= '0;
         base_ff   <= '0;
         blen_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            vafc_pkg::CSR_ATTR_TYPE:     type_ff   <= csr_data[3:0];
            vafc_pkg::CSR_COMP_COUNT:    cnt_ff    <= csr_data[2:0];
            vafc_pkg::CSR_NORMALIZED:    norm_ff   <= csr_data[0];
            vafc_pkg::CSR_STRIDE:        stride_ff <= csr_data[11:0];
            vafc_pkg::CSR_BASE_OFFSET:   base_ff   <= csr_data;
            vafc_pkg::CSR_BUFFER_LENGTH: blen_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // stage handshake
   logic [7:1] valid_ff;
   logic [7:1] en_c;

   always_comb begin
      en_c[7] = !valid_ff[7] || rsp_ready;
      for (int k = 6; k >= 1; k--) begin
         en_c[k] = !valid_ff[k] || en_c[k+1];
      end
   end

   assign req_ready = en_c[1];
   assign rsp_valid = valid_ff[7];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en_c[1]) valid_ff[1] <= req_valid;
         for (int k = 2; k <= 7; k++) begin
            if (en_c[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // stage 1: checks and stride multiply
   logic [3:0]  tsize_c;
   logic [5:0]  total_c;
   logic [11:0] eff_c;
   logic [43:0] prod_c;

   always_comb begin
      tsize_c = type_bytes(type_ff);
      total_c = 6'(tsize_c * cnt_ff);
      eff_c   = (stride_ff != 12'd0) ? stride_ff : 12'(total_c);
      prod_c  = {12'b0, req_data.index} * {32'b0, eff_c};
   end

   logic         mode1_ff, cntbad1_ff, typebad1_ff, rej1_ff;
   logic [43:0]  prod1_ff;
   logic [5:0]   total1_ff;
   logic [255:0] raw1_ff;

   always_ff @(posedge clock) begin
      if (en_c[1]) begin
         mode1_ff    <= req_data.mode;
         prod1_ff    <= prod_c;
         total1_ff   <= total_c;
         cntbad1_ff  <= (cnt_ff == 3'd0) || (cnt_ff > 3'(MAX_COMPONENTS));
         typebad1_ff <= tsize_c == 4'd0;
         rej1_ff     <= (type_ff == vafc_pkg::ATTR_FIXED) ||
                        (type_ff == vafc_pkg::ATTR_F101111);
         raw1_ff     <= {req_data.raw_3, req_data.raw_2, req_data.raw_1, req_data.raw_0};
      end
   end

   // stage 2: offset and bounds
   logic [44:0] off_c;
   logic [45:0] end_c;
   logic [1:0]  stat_c;

   always_comb begin
      off_c = {1'b0, prod1_ff} + 45'(base_ff);
      end_c = {1'b0, off_c} + 46'(total1_ff);
      if (cntbad1_ff) begin
         stat_c = vafc_pkg::STAT_SIZE;
      end else if (typebad1_ff) begin
         stat_c = vafc_pkg::STAT_TYPE;
      end else if (end_c > 46'(blen_ff)) begin
         stat_c = vafc_pkg::STAT_OOB;
      end else if (rej1_ff) begin
         stat_c = vafc_pkg::STAT_TYPE;
      end else begin
         stat_c = vafc_pkg::STAT_OK;
      end
   end

   logic [1:0]  stat_ff [2:6];
   logic [43:0] off_ff  [2:6];

   always_ff @(posedge clock) begin
      if (en_c[2]) begin
         stat_ff[2] <= stat_c;
         off_ff[2]  <= off_c[43:0];
      end
      for (int k = 3; k <= 6; k++) begin
         if (en_c[k]) begin
            stat_ff[k] <= stat_ff[k-1];
            off_ff[k]  <= off_ff[k-1];
         end
      end
   end

   vafc_pkg::lane_cfg_type lane_cfg;
   logic [63:0]            comp_c [4];

   assign lane_cfg = '{attr_type: type_ff, normalized: norm_ff};

   for (genvar g = 0; g < 4; g++) begin : g_lane
      if (g < MAX_COMPONENTS) begin : g_on
         vafc_lane #(
            .LANE(g)
         ) u_lane (
            .clock    (clock),
            .stage_en (en_c[6:2]),
            .cfg      (lane_cfg),
            .mode_in  (mode1_ff),
            .raw_in   (raw1_ff),
            .comp_out (comp_c[g])
         );
      end else begin : g_off
         assign comp_c[g] = '0;
      end
   end

   // stage 7: output register
   logic        ok_c;
   logic [63:0] keep_c [4];

   always_comb begin
      ok_c = stat_ff[6] == vafc_pkg::STAT_OK;
      for (int i = 0; i < 4; i++) begin
         keep_c[i] = (ok_c && (3'(i) < cnt_ff)) ? comp_c[i] : 64'd0;
      end
   end

   vafc_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (en_c[7]) begin
         rsp_data_ff.status      <= stat_ff[6];
         rsp_data_ff.byte_offset <= ok_c ? off_ff[6] : 44'd0;
         rsp_data_ff.comp_0      <= keep_c[0];
         rsp_data_ff.comp_1      <= keep_c[1];
         rsp_data_ff.comp_2      <= keep_c[2];
         rsp_data_ff.comp_3      <= keep_c[3];
      end
   end

   assign rsp_data = rsp_data_ff;

`ifndef SYNTH
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (valid_ff == 7'h7F))
      else $error("input stalled while a stage is empty");

   a_accept_fills_stage1: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[1])
      else $error("accepted transaction lost at stage 1");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != vafc_pkg::STAT_OK) |->
         (rsp_data.byte_offset == 44'd0) && (rsp_data.comp_0 == 64'd0))
      else $error("error response carries data");

   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (cnt_ff < 3'd2) |-> (rsp_data.comp_1 == 64'd0))
      else $error("component beyond count not zero");

   a_stall_holds_output: assert property (@(posedge clock) disable iff (reset)
      valid_ff[7] && !rsp_ready |=> valid_ff[7])
      else $error("response dropped during stall");
`endif

endmodule
